@@ src/ikht_pkg.sv @@
package ikht_pkg;

  localparam int SLOTS = 256;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = 17;
  localparam int PROBE_W = IDX_W + 1;
  localparam logic [31:0] HASH_MULT = 32'h85eb_ca6b;
  localparam int HASH_SHIFT = 16;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic ACT_SET = 1'b0;
  localparam logic ACT_GET = 1'b1;

  // classified request handed from front to back
  typedef struct packed {
    logic act;
    logic key_zero;
    logic [31:0] key;
    logic [31:0] value;
    logic [IDX_W-1:0] home;
  } req_t;

endpackage

@@ src/ikht_front.sv @@
// Input stage: registered multiply, then xor-shift into a small queue.
module ikht_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic action,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic q_valid,
  input  logic q_pop,
  output ikht_pkg::req_t q_data
);

  // stage 1: multiply
  logic s1_valid;
  logic s1_act;
  logic [31:0] s1_key;
  logic [31:0] s1_value;
  logic [31:0] s1_prod;

  ikht_pkg::req_t q_mem [ikht_pkg::QDEPTH];
  logic [ikht_pkg::QPTR_W-1:0] wr_ptr;
  logic [ikht_pkg::QPTR_W-1:0] rd_ptr;
  logic [ikht_pkg::QPTR_W:0] q_cnt;

  logic [31:0] mix;
  ikht_pkg::req_t s2_req;
  logic push;
  logic s1_adv;

  // stage 1 drains into queue whenever there is room
  assign push = s1_valid && (q_cnt != (ikht_pkg::QPTR_W+1)'(ikht_pkg::QDEPTH));
  assign s1_adv = !s1_valid || push;
  assign in_stall = !s1_adv;

  always_comb begin
    mix = s1_prod ^ (s1_prod >> ikht_pkg::HASH_SHIFT);
    s2_req.act = s1_act;
    s2_req.key_zero = (s1_key == 32'd0);
    s2_req.key = s1_key;
    s2_req.value = s1_value;
    s2_req.home = mix[ikht_pkg::IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= in_valid;
    end
    if (s1_adv && in_valid) begin
      s1_act <= action;
      s1_key <= key;
      s1_value <= value;
      s1_prod <= key * ikht_pkg::HASH_MULT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_cnt <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      q_cnt <= q_cnt + (ikht_pkg::QPTR_W+1)'(push) - (ikht_pkg::QPTR_W+1)'(q_pop);
    end
    if (push) q_mem[wr_ptr] <= s2_req;
  end

  assign q_valid = (q_cnt != '0);
  assign q_data = q_mem[rd_ptr];

endmodule

@@ src/ikht_back.sv @@
// Probe engine: serial slot probes, one result register.
module ikht_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_pop,
  input  ikht_pkg::req_t q_data,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] status,
  output logic [31:0] read_value,
  output logic [16:0] entry_count
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_VAL   = 5'b10000
  } state_t;

  state_t state;
  logic [31:0] key_mem [ikht_pkg::SLOTS];
  logic [31:0] val_mem [ikht_pkg::SLOTS];
  logic [31:0] rd_key;
  logic [31:0] rd_val;
  ikht_pkg::req_t req;
  logic [ikht_pkg::IDX_W-1:0] idx;
  logic [ikht_pkg::IDX_W-1:0] clr_idx;
  logic [ikht_pkg::PROBE_W-1:0] probes;
  logic [ikht_pkg::CNT_W-1:0] occupied;

  logic kw_en;
  logic [31:0] kw_data;
  logic vw_en;
  logic full;
  logic hit;
  logic empty_slot;
  logic out_free;
  logic last_probe;

  assign out_free = !out_valid || !out_stall;
  assign full = occupied >= ikht_pkg::CNT_W'(ikht_pkg::SLOTS - 1);
  assign hit = (rd_key == req.key);
  assign empty_slot = (rd_key == 32'd0);
  assign last_probe = (probes == ikht_pkg::PROBE_W'(ikht_pkg::SLOTS - 1));
  assign q_pop = (state == S_IDLE) && q_valid && out_free;

  always_comb begin
    kw_en = 1'b0;
    kw_data = req.key;
    vw_en = 1'b0;
    unique case (state)
      S_CLEAR: begin
        kw_en = 1'b1;
        kw_data = 32'd0;
      end
      S_EVAL: begin
        if (req.act == ikht_pkg::ACT_SET) begin
          if (empty_slot) begin
            kw_en = 1'b1;
            vw_en = 1'b1;
          end else if (hit) begin
            if (req.value != 32'd0) begin
              vw_en = 1'b1;
            end else begin
              kw_en = 1'b1;
              kw_data = 32'd0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (kw_en) key_mem[(state == S_CLEAR) ? clr_idx : idx] <= kw_data;
    if (vw_en) val_mem[idx] <= req.value;
    rd_key <= key_mem[idx];
    rd_val <= val_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      occupied <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == ikht_pkg::IDX_W'(ikht_pkg::SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_pop) begin
            req <= q_data;
            idx <= q_data.home;
            probes <= '0;
            if (q_data.key_zero) begin
              out_valid <= 1'b1;
              status <= ikht_pkg::ST_ZERO;
              read_value <= 32'd0;
              entry_count <= occupied;
            end else if (q_data.act == ikht_pkg::ACT_SET && full) begin
              out_valid <= 1'b1;
              status <= ikht_pkg::ST_MISS;
              read_value <= 32'd0;
              entry_count <= occupied;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: state <= S_EVAL;
        S_EVAL: begin
          if (req.act == ikht_pkg::ACT_SET) begin
            if (empty_slot || hit) begin
              out_valid <= 1'b1;
              status <= ikht_pkg::ST_OK;
              read_value <= 32'd0;
              if (empty_slot) begin
                entry_count <= occupied + 1'b1;
                occupied <= occupied + 1'b1;
              end else if (req.value == 32'd0) begin
                entry_count <= occupied - 1'b1;
                occupied <= occupied - 1'b1;
              end else begin
                entry_count <= occupied;
              end
              state <= S_IDLE;
            end
          end else if (hit) begin
            state <= S_VAL;
          end else if (empty_slot) begin
            out_valid <= 1'b1;
            status <= ikht_pkg::ST_MISS;
            read_value <= 32'd0;
            entry_count <= occupied;
            state <= S_IDLE;
          end
          if (!(empty_slot || hit)) begin
            if (last_probe) begin
              out_valid <= 1'b1;
              status <= ikht_pkg::ST_MISS;
              read_value <= 32'd0;
              entry_count <= occupied;
              state <= S_IDLE;
            end else begin
              idx <= idx + 1'b1;
              probes <= probes + 1'b1;
              state <= S_READ;
            end
          end
        end
        S_VAL: begin
          // value read issued in S_EVAL at the hit index
          out_valid <= 1'b1;
          status <= ikht_pkg::ST_OK;
          read_value <= rd_val;
          entry_count <= occupied;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/int_key_hash_table.sv @@
// Channel | Handshake         | Payload
// in      | in_valid/in_stall | action, key, value
// out     | out_valid/out_stall | status, read_value, entry_count
//
// Path: the front hashes (registered multiply, xor-shift into its queue);
// per probed slot the probe engine does a registered key-memory read, then
// a compare, plus a value read for a get hit. It sets the pace, one item
// at a time; key zero and full-table sets finish at dispatch. Reset: a
// clearing pass over all 256 slots empties the key store; items queue in
// the front meanwhile. A stalled output holds; the front hashes until full.
module int_key_hash_table (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic action,
  input  logic [31:0] key,
  input  logic [31:0] value,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] status,
  output logic [31:0] read_value,
  output logic [16:0] entry_count
);

  logic q_valid;
  logic q_pop;
  ikht_pkg::req_t q_data;

  ikht_front u_front (
    .clk, .rst, .in_valid, .in_stall, .action, .key, .value,
    .q_valid, .q_pop, .q_data
  );

  ikht_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_data,
    .out_valid, .out_stall, .status, .read_value, .entry_count
  );

endmodule

@@ src/ikht_checker.sv @@
module ikht_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic [1:0] status,
  input logic [31:0] read_value,
  input logic [16:0] entry_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(entry_count))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ikht_pkg::ST_ZERO)
    else $error("bad status");

  a_rv_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ikht_pkg::ST_OK |-> read_value == 32'd0)
    else $error("read_value nonzero on miss");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= 17'(ikht_pkg::SLOTS - 1))
    else $error("count beyond capacity");

endmodule

bind int_key_hash_table ikht_checker u_chk (.*);

@@ tb/tb_int_key_hash_table.sv @@
module tb_int_key_hash_table;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected result of one item
  typedef struct {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [16:0] entry_count;
  } table_result_t;

  // Shadow copy of the table plus a queue of results still due from the block
  class table_scoreboard;
    logic [31:0] keys[ikht_pkg::SLOTS];
    logic [31:0] vals[ikht_pkg::SLOTS];
    logic [16:0] count;
    table_result_t pending[$];
    int errors;
    int checked;
    int hits;
    int fulls;

    function new();
      foreach (keys[i]) keys[i] = '0;
      foreach (vals[i]) vals[i] = '0;
      count = '0;
      errors = 0;
      checked = 0;
      hits = 0;
      fulls = 0;
    endfunction

    function logic [ikht_pkg::IDX_W-1:0] home_of(logic [31:0] k);
      logic [31:0] h;
      h = k * ikht_pkg::HASH_MULT;
      h = h ^ (h >> ikht_pkg::HASH_SHIFT);
      return h[ikht_pkg::IDX_W-1:0];
    endfunction

    // Apply one accepted item to the shadow table and queue its result
    function void note_item(logic act, logic [31:0] k, logic [31:0] v);
      table_result_t r;
      logic [ikht_pkg::IDX_W-1:0] idx;
      bit done;
      r.status = ikht_pkg::ST_MISS;
      r.read_value = '0;
      idx = home_of(k);
      done = 0;
      if (k == 0) begin
        r.status = ikht_pkg::ST_ZERO;
      end else if (act == ikht_pkg::ACT_SET) begin
        if (count >= ikht_pkg::SLOTS - 1) begin
          fulls++;
        end else begin
          for (int n = 0; n < ikht_pkg::SLOTS && !done; n++) begin
            if (keys[idx] == 0) begin
              keys[idx] = k;
              vals[idx] = v;
              count++;
              r.status = ikht_pkg::ST_OK;
              done = 1;
            end else if (keys[idx] == k) begin
              if (v != 0) vals[idx] = v;
              else begin
                // removal leaves later chains broken
                keys[idx] = '0;
                count--;
              end
              r.status = ikht_pkg::ST_OK;
              done = 1;
            end
            idx++;
          end
        end
      end else begin
        for (int n = 0; n < ikht_pkg::SLOTS && !done; n++) begin
          if (keys[idx] == k) begin
            r.status = ikht_pkg::ST_OK;
            r.read_value = vals[idx];
            hits++;
            done = 1;
          end else if (keys[idx] == 0) begin
            done = 1;
          end
          idx++;
        end
      end
      r.entry_count = count;
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [31:0] rv, logic [16:0] ec);
      table_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: status=%0d read_value=%h entry_count=%0d", st, rv, ec);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        errors++;
      end
      if (rv !== e.read_value) begin
        $error("read_value: expected %h, actual %h", e.read_value, rv);
        errors++;
      end
      if (ec !== e.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", e.entry_count, ec);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic action = 0;
  logic [31:0] key = '0;
  logic [31:0] value = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [1:0] status;
  logic [31:0] read_value;
  logic [16:0] entry_count;

  int unsigned cycles = 0;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  table_scoreboard sb = new();
  bit stim_done = 0;
  bit hold_off = 0;     // long receiver stall request
  logic [31:0] key_pool[16];

  int_key_hash_table uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .key(key), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .read_value(read_value), .entry_count(entry_count)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Monitor: outputs are sampled at the edge, before any NBA update lands
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(status, read_value, entry_count);
    if (!rst && in_valid && !in_stall)
      sb.note_item(action, key, value);
  end

  // Receiver: random stalls per item, stretches of none, plus the long hold-off
  initial begin
    int w;
    int mode;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off) begin
        out_stall <= 1;
        @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        w = (mode == 0) ? 0 : $urandom_range(0, 16);
        if (w > 0) begin
          out_stall <= 1;
          repeat (w) @(posedge clk);
        end
        out_stall <= 0;
        @(posedge clk iff out_valid);
      end
    end
  end

  // Offer one item and wait for its acceptance; valid stays high between back-to-back items
  task automatic send_item(logic act, logic [31:0] k, logic [31:0] v, int gap);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    action <= act;
    key <= k;
    value <= v;
    @(posedge clk iff !in_stall);
  endtask

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic logic draw_act();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return key_pool[$urandom_range(0, 15)];
    if (sel < 9) return $urandom;
    return 32'h0;
  endfunction

  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 32'h0;
    if (sel == 1) return 32'hffff_ffff;
    return $urandom;
  endfunction

  initial begin
    logic [31:0] k;
    repeat (8) @(posedge clk);
    rst <= 0;
    foreach (key_pool[i]) key_pool[i] = $urandom | 32'h1;

    // Directed: key zero, extremes, insert/update/get, zero-value insert, removal
    send_item(ikht_pkg::ACT_SET, 32'h0, 32'h1234, 0);
    send_item(ikht_pkg::ACT_GET, 32'h0, 32'hffff_ffff, 0);
    send_item(ikht_pkg::ACT_GET, 32'h1, 32'h0, 0);             // absent on empty table
    send_item(ikht_pkg::ACT_SET, 32'hffff_ffff, 32'hffff_ffff, 0);
    send_item(ikht_pkg::ACT_GET, 32'hffff_ffff, 32'h0, 0);
    send_item(ikht_pkg::ACT_SET, 32'h1, 32'h0, 1);             // new key with value zero
    send_item(ikht_pkg::ACT_GET, 32'h1, 32'h0, 0);
    send_item(ikht_pkg::ACT_SET, 32'h8000_0000, 32'h5555_aaaa, 2);
    send_item(ikht_pkg::ACT_SET, 32'h8000_0000, 32'haaaa_5555, 0);  // update
    send_item(ikht_pkg::ACT_GET, 32'h8000_0000, 32'h0, 0);
    send_item(ikht_pkg::ACT_SET, 32'h8000_0000, 32'h0, 0);     // removal
    send_item(ikht_pkg::ACT_GET, 32'h8000_0000, 32'h0, 0);
    send_item(ikht_pkg::ACT_SET, 32'h1, 32'h0, 3);             // remove zero-valued key
    send_item(ikht_pkg::ACT_GET, 32'h1, 32'h0, 0);

    // Long receiver hold-off while the sender keeps going
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 40; i++)
        send_item(draw_act(), key_pool[i % 16], $urandom, 0);
    join

    // Random: pool keys give hits, updates and removals
    for (int i = 0; i < 600; i++)
      send_item(draw_act(), pick_key(), pick_value(), draw_gap());

    // Fill toward capacity to reach the full-table case and long probes
    for (int i = 0; i < 330; i++) begin
      k = (i % 4 == 3) ? key_pool[$urandom_range(0, 15)] : $urandom;
      send_item((i % 5 == 4) ? ikht_pkg::ACT_GET : ikht_pkg::ACT_SET, k, $urandom | 32'h1,
                (i % 3 == 0) ? draw_gap() : 0);
    end
    for (int i = 0; i < 60; i++)
      send_item(draw_act(), pick_key(), pick_value(), draw_gap());
    send_item(ikht_pkg::ACT_GET, 32'h0, 32'h0, 0);
    in_valid <= 0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    $display("Checked %0d results: %0d get hits, %0d sets refused on a full table.",
             sb.checked, sb.hits, sb.fulls);
    $display("Final occupancy %0d of %0d slots.", sb.count, ikht_pkg::SLOTS);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
src/ikht_pkg.sv
src/ikht_front.sv
src/ikht_back.sv
src/int_key_hash_table.sv
src/ikht_checker.sv
tb/tb_int_key_hash_table.sv
